// ===== rtl/core/slab_pkg.sv =====
// Shared constants, types and helper functions for the slab size-class allocator.
package slab_pkg;

    localparam int CLASS_COUNT     = 7;
    localparam int PAGE_BYTES      = 4096;
    localparam int MIN_BLOCK_BYTES = 16;

    localparam int SLOTS_MAX  = PAGE_BYTES / MIN_BLOCK_BYTES;
    localparam int SLOT_W     = $clog2(SLOTS_MAX);
    // Class c uses SLOTS_MAX >> c link entries, so all classes fit in twice SLOTS_MAX.
    localparam int LINK_DEPTH = 2 * SLOTS_MAX;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    localparam int OFF_W      = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = 32 - OFF_W;
    localparam int MIN_SHIFT  = $clog2(MIN_BLOCK_BYTES);
    localparam int CLASS_W    = 3;
    localparam int COUNT_W    = 16;
    localparam int REPORT_W   = 9;

    localparam logic [CLASS_W-1:0] NO_CLASS = 3'd7;

    typedef enum logic [2:0] {
        ST_ALLOCATED   = 3'd0,
        ST_FREED       = 3'd1,
        ST_TOO_LARGE   = 3'd2,
        ST_EXHAUSTED   = 3'd3,
        ST_NOT_IN_POOL = 3'd4,
        ST_NULL        = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REQ_ALLOC      = 2'd0,
        REQ_FREE_SIZED = 2'd1,
        REQ_FREE_PTR   = 2'd2,
        REQ_UNUSED     = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ALLOC,
        OP_FREE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [CLASS_W-1:0]  cls;
        logic [SLOT_W-1:0]   slot;
        status_t             status;
    } dec_t;

    function automatic logic [31:0] class_bytes(input logic [CLASS_W-1:0] c);
        return 32'(MIN_BLOCK_BYTES) << c;
    endfunction

    function automatic logic [COUNT_W-1:0] class_blocks(input logic [CLASS_W-1:0] c);
        return COUNT_W'(SLOTS_MAX) >> c;
    endfunction

    // The depth itself does not fit in the address width, so the difference is formed at full width.
    function automatic logic [LINK_AW-1:0] link_base(input logic [CLASS_W-1:0] c);
        return LINK_AW'(LINK_DEPTH - (LINK_DEPTH >> c));
    endfunction

    // Reset contents of one link entry: each class chained in slot order, last link 0.
    function automatic logic [SLOT_W-1:0] link_init(input logic [LINK_AW-1:0] a);
        logic [SLOT_W-1:0]  val;
        logic [LINK_AW:0]   s;
        logic [LINK_AW:0]   lo;
        logic [LINK_AW:0]   n;
        val = '0;
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            lo = (LINK_AW+1)'(link_base(CLASS_W'(c)));
            n  = (LINK_AW+1)'(SLOTS_MAX >> c);
            s  = (LINK_AW+1)'(a) - lo;
            if (((LINK_AW+1)'(a) >= lo) && (s < n))
            begin
                val = (s + 1'b1 < n) ? SLOT_W'(s + 1'b1) : '0;
            end
        end
        return val;
    endfunction

endpackage

// ===== rtl/core/slab_decode.sv =====
// Request decoder: size class choice, page match and slot extraction.
module slab_decode
    import slab_pkg::*;
(
    input  logic [1:0]        req_type,
    input  logic [31:0]       req_size,
    input  logic [31:0]       address,
    input  logic [PAGE_W-1:0] base_page,
    output dec_t              dec
);

    logic [CLASS_W-1:0]     size_cls;
    logic [CLASS_W-1:0]     ptr_cls;
    logic                   ptr_hit;
    logic [CLASS_COUNT-1:0] hit;
    logic [OFF_W-1:0]       offset;

    assign offset = address[OFF_W-1:0];

    always_comb
    begin
        size_cls = NO_CLASS;
        for (int c = CLASS_COUNT - 1; c >= 0; c--)
        begin
            if (req_size <= class_bytes(CLASS_W'(c)))
            begin
                size_cls = CLASS_W'(c);
            end
        end
    end

    // Pages are aligned, so a pointer lies in a page when its page number matches.
    always_comb
    begin
        ptr_cls = NO_CLASS;
        ptr_hit = 1'b0;
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            hit[c] = (address[31:OFF_W] == PAGE_W'(base_page + PAGE_W'(c)));
        end
        for (int c = CLASS_COUNT - 1; c >= 0; c--)
        begin
            if (hit[c])
            begin
                ptr_cls = CLASS_W'(c);
                ptr_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        dec.op     = OP_NONE;
        dec.cls    = NO_CLASS;
        dec.slot   = '0;
        dec.status = ST_NULL;
        priority if (req_type_t'(req_type) == REQ_ALLOC)
        begin
            if (size_cls == NO_CLASS)
            begin
                dec.status = ST_TOO_LARGE;
            end
            else
            begin
                dec.op     = OP_ALLOC;
                dec.cls    = size_cls;
                dec.status = ST_ALLOCATED;
            end
        end
        else if ((req_type_t'(req_type) == REQ_UNUSED) || (address == '0))
        begin
            dec.status = ST_NULL;
        end
        else if (req_type_t'(req_type) == REQ_FREE_SIZED)
        begin
            if (size_cls == NO_CLASS)
            begin
                dec.status = ST_TOO_LARGE;
            end
            else
            begin
                dec.cls = size_cls;
                if (hit[size_cls])
                begin
                    dec.op     = OP_FREE;
                    dec.status = ST_FREED;
                    dec.slot   = SLOT_W'(offset >> (MIN_SHIFT + size_cls));
                end
                else
                begin
                    dec.status = ST_NOT_IN_POOL;
                end
            end
        end
        else
        begin
            if (ptr_hit)
            begin
                dec.op     = OP_FREE;
                dec.cls    = ptr_cls;
                dec.status = ST_FREED;
                dec.slot   = SLOT_W'(offset >> (MIN_SHIFT + ptr_cls));
            end
            else
            begin
                dec.status = ST_NOT_IN_POOL;
            end
        end
    end

endmodule

// ===== rtl/core/slab_link_ram.sv =====
// Next-slot link memory for all classes, with a fill pass that builds the lists after reset.
module slab_link_ram
    import slab_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [LINK_AW-1:0] rd_addr,
    output logic [SLOT_W-1:0]  rd_data,
    input  logic               wr_en,
    input  logic [LINK_AW-1:0] wr_addr,
    input  logic [SLOT_W-1:0]  wr_data,
    output logic               busy
);

    logic [SLOT_W-1:0]  mem [LINK_DEPTH];
    logic [LINK_AW:0]   fill_reg;
    logic [SLOT_W-1:0]  rd_data_reg;

    assign busy    = !fill_reg[LINK_AW];
    assign rd_data = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (busy)
        begin
            fill_reg <= fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            mem[fill_reg[LINK_AW-1:0]] <= link_init(fill_reg[LINK_AW-1:0]);
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/slab_size_class_allocator.sv =====
// Top level of the slab size-class allocator: control, list heads, counts and result register.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+----------------------------------------------
//  request  | req_valid / req_ready     | req_type, req_size, address
//  result   | rsp_valid / rsp_ready     | status, block_address, class_index, free_blocks
//  config   | base_page_we              | base_page_wdata
//
// An allocation reads the head's link from the link memory into a register at the accept
// edge; in the S_EXEC state that follows, an allocation or free updates head and count,
// and every request loads the result register. After reset a fill pass builds the free
// lists; no request is accepted during it, and the first one can be taken once the state
// has moved from S_FILL to S_IDLE. In S_IDLE a request is accepted while the result register
// is empty or being taken, so at most one result waits in the block and a stalled result holds the request channel off.
module slab_size_class_allocator
    import slab_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          req_type,
    input  logic [31:0]         req_size,
    input  logic [31:0]         address,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [2:0]          status,
    output logic [31:0]         block_address,
    output logic [CLASS_W-1:0]  class_index,
    output logic [REPORT_W-1:0] free_blocks,
    input  logic                base_page_we,
    input  logic [PAGE_W-1:0]   base_page_wdata
);

    typedef enum logic [1:0] {
        S_FILL,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t               state_reg;
    logic [PAGE_W-1:0]    base_page_reg;
    logic [SLOT_W-1:0]    head_reg  [CLASS_COUNT];
    logic [COUNT_W-1:0]   count_reg [CLASS_COUNT];

    op_t                  op_reg;
    logic [CLASS_W-1:0]   cls_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    head_sel_reg;
    logic [COUNT_W-1:0]   count_sel_reg;
    status_t              status_reg;

    logic                 rsp_valid_reg;
    status_t              rsp_status_reg;
    logic [31:0]          rsp_addr_reg;
    logic [CLASS_W-1:0]   rsp_class_reg;
    logic [REPORT_W-1:0]  rsp_free_reg;

    dec_t                 dec;
    logic                 accept;
    logic                 fill_busy;
    logic [CLASS_W-1:0]   sel_cls;
    logic [SLOT_W-1:0]    head_sel;
    logic [COUNT_W-1:0]   count_sel;
    logic                 exhausted;
    logic                 rd_en;
    logic [LINK_AW-1:0]   rd_addr;
    logic [SLOT_W-1:0]    rd_data;
    logic                 wr_en;
    logic [LINK_AW-1:0]   wr_addr;
    logic [COUNT_W-1:0]   count_dec;
    logic [COUNT_W-1:0]   count_inc;
    logic [PAGE_W-1:0]    alloc_page;
    logic [OFF_W-1:0]     alloc_off;

    slab_decode u_decode (
        .req_type  (req_type),
        .req_size  (req_size),
        .address   (address),
        .base_page (base_page_reg),
        .dec       (dec)
    );

    slab_link_ram u_link_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (head_sel_reg),
        .busy    (fill_busy)
    );

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    assign sel_cls   = (dec.cls == NO_CLASS) ? '0 : dec.cls;
    assign head_sel  = head_reg[sel_cls];
    assign count_sel = count_reg[sel_cls];
    assign exhausted = (dec.op == OP_ALLOC) && (count_sel == '0);

    assign rd_en   = accept && (dec.op == OP_ALLOC) && !exhausted;
    assign rd_addr = link_base(sel_cls) + LINK_AW'(head_sel);

    // A free links the freed slot to the old head.
    assign wr_en   = (state_reg == S_EXEC) && (op_reg == OP_FREE);
    assign wr_addr = link_base(cls_reg) + LINK_AW'(slot_reg);

    assign count_dec  = count_sel_reg - 1'b1;
    assign count_inc  = (count_sel_reg == '1) ? count_sel_reg : count_sel_reg + 1'b1;
    assign alloc_page = base_page_reg + PAGE_W'(cls_reg);
    assign alloc_off  = OFF_W'(slot_reg) << (MIN_SHIFT + cls_reg);

    assign rsp_valid     = rsp_valid_reg;
    assign status        = rsp_status_reg;
    assign block_address = rsp_addr_reg;
    assign class_index   = rsp_class_reg;
    assign free_blocks   = rsp_free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_page_reg <= PAGE_W'(1);
        end
        else if (base_page_we)
        begin
            base_page_reg <= base_page_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FILL;
            rsp_valid_reg  <= 1'b0;
            op_reg         <= OP_NONE;
            cls_reg        <= NO_CLASS;
            slot_reg       <= '0;
            head_sel_reg   <= '0;
            count_sel_reg  <= '0;
            status_reg     <= ST_NULL;
            rsp_status_reg <= ST_NULL;
            rsp_addr_reg   <= '0;
            rsp_class_reg  <= NO_CLASS;
            rsp_free_reg   <= '0;
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                head_reg[c]  <= '0;
                count_reg[c] <= class_blocks(CLASS_W'(c));
            end
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_FILL:
                begin
                    if (!fill_busy)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg     <= S_EXEC;
                        cls_reg       <= dec.cls;
                        head_sel_reg  <= head_sel;
                        count_sel_reg <= count_sel;
                        if (exhausted)
                        begin
                            op_reg     <= OP_NONE;
                            status_reg <= ST_EXHAUSTED;
                            slot_reg   <= '0;
                        end
                        else
                        begin
                            op_reg     <= dec.op;
                            status_reg <= dec.status;
                            slot_reg   <= (dec.op == OP_ALLOC) ? head_sel : dec.slot;
                        end
                    end
                end
                S_EXEC:
                begin
                    state_reg      <= S_IDLE;
                    rsp_valid_reg  <= 1'b1;
                    rsp_status_reg <= status_reg;
                    rsp_class_reg  <= cls_reg;
                    unique case (op_reg)
                        OP_ALLOC:
                        begin
                            head_reg[cls_reg]  <= rd_data;
                            count_reg[cls_reg] <= count_dec;
                            rsp_free_reg       <= count_dec[REPORT_W-1:0];
                            rsp_addr_reg       <= {alloc_page, alloc_off};
                        end
                        OP_FREE:
                        begin
                            head_reg[cls_reg]  <= slot_reg;
                            count_reg[cls_reg] <= count_inc;
                            rsp_free_reg       <= count_inc[REPORT_W-1:0];
                            rsp_addr_reg       <= '0;
                        end
                        default:
                        begin
                            rsp_addr_reg <= '0;
                            rsp_free_reg <= (cls_reg == NO_CLASS) ?
                                            '0 : count_sel_reg[REPORT_W-1:0];
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= S_FILL;
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/slab_reply_checker.sv =====
// Checker for the slab allocator: mirrors the free lists, predicts each reply and compares it.
`timescale 1ns / 100ps

module slab_reply_checker
    import slab_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  logic [1:0]          req_type,
    input  logic [31:0]         req_size,
    input  logic [31:0]         address,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  logic [2:0]          status,
    input  logic [31:0]         block_address,
    input  logic [CLASS_W-1:0]  class_index,
    input  logic [REPORT_W-1:0] free_blocks,
    input  logic                base_page_we,
    input  logic [PAGE_W-1:0]   base_page_wdata,
    output int                  failures,
    output int                  pending
);

    typedef struct {
        status_t              st;
        logic [31:0]          addr;
        logic [CLASS_W-1:0]   cls;
        logic [REPORT_W-1:0]  cnt;
    } reply_t;

    logic [PAGE_W-1:0]  base_page;
    logic [SLOT_W-1:0]  link_next [CLASS_COUNT][SLOTS_MAX];
    logic [SLOT_W-1:0]  head_slot [CLASS_COUNT];
    logic [COUNT_W-1:0] blocks_free [CLASS_COUNT];
    reply_t             awaited_replies [$];

    function automatic logic [31:0] block_span(int c);
        return 32'(MIN_BLOCK_BYTES) << c;
    endfunction

    function automatic logic [31:0] page_addr(int c);
        return 32'((64'(base_page) + 64'(c)) * 64'(PAGE_BYTES));
    endfunction

    // Smallest class that holds the size; CLASS_COUNT when none does.
    function automatic int size_class(logic [31:0] size);
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            if (size <= block_span(c))
                return c;
        end
        return CLASS_COUNT;
    endfunction

    function automatic reply_t make_reply(status_t st, logic [31:0] a, int c);
        reply_t r;
        r.st   = st;
        r.addr = a;
        if (c < CLASS_COUNT)
        begin
            r.cls = CLASS_W'(c);
            r.cnt = blocks_free[c][REPORT_W-1:0];
        end
        else
        begin
            r.cls = NO_CLASS;
            r.cnt = '0;
        end
        return r;
    endfunction

    function automatic reply_t push_slot(int c, logic [31:0] off);
        logic [31:0] slot;
        slot = off / block_span(c);
        if (slot >= 32'(SLOTS_MAX >> c))
            return make_reply(ST_NOT_IN_POOL, '0, c);
        link_next[c][slot] = head_slot[c];
        head_slot[c] = SLOT_W'(slot);
        if (blocks_free[c] != '1)
            blocks_free[c] = blocks_free[c] + 1'b1;
        return make_reply(ST_FREED, '0, c);
    endfunction

    // Applies one request to the mirrored lists and returns the reply it should get.
    function automatic reply_t serve_request(req_type_t kind, logic [31:0] size,
                                             logic [31:0] addr);
        int          c;
        logic [31:0] off;
        logic [31:0] slot;
        if (kind == REQ_ALLOC)
        begin
            c = size_class(size);
            if (c >= CLASS_COUNT)
                return make_reply(ST_TOO_LARGE, '0, CLASS_COUNT);
            if (blocks_free[c] == '0)
                return make_reply(ST_EXHAUSTED, '0, c);
            slot = 32'(head_slot[c]);
            head_slot[c] = link_next[c][slot];
            blocks_free[c] = blocks_free[c] - 1'b1;
            return make_reply(ST_ALLOCATED, page_addr(c) + slot * block_span(c), c);
        end
        // The null check comes ahead of every other free check.
        if (kind == REQ_UNUSED || addr == '0)
            return make_reply(ST_NULL, '0, CLASS_COUNT);
        if (kind == REQ_FREE_SIZED)
        begin
            c = size_class(size);
            if (c >= CLASS_COUNT)
                return make_reply(ST_TOO_LARGE, '0, CLASS_COUNT);
            off = addr - page_addr(c);
            if (off >= 32'(PAGE_BYTES))
                return make_reply(ST_NOT_IN_POOL, '0, c);
            return push_slot(c, off);
        end
        for (c = 0; c < CLASS_COUNT; c++)
        begin
            off = addr - page_addr(c);
            if (off < 32'(PAGE_BYTES))
                return push_slot(c, off);
        end
        return make_reply(ST_NOT_IN_POOL, '0, CLASS_COUNT);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        if (!rst_n)
        begin
            base_page = PAGE_W'(1);
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                for (int s = 0; s < SLOTS_MAX; s++)
                    link_next[c][s] = (s + 1 < (SLOTS_MAX >> c)) ? SLOT_W'(s + 1) : '0;
                head_slot[c]   = '0;
                blocks_free[c] = COUNT_W'(SLOTS_MAX >> c);
            end
            awaited_replies.delete();
            pending  = 0;
            failures = 0;
        end
        else
        begin
            if (base_page_we)
                base_page = base_page_wdata;
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $error("reply with no request outstanding: status %0d", status);
                    failures++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, actual %0d", want.st, status);
                        failures++;
                    end
                    if (block_address !== want.addr)
                    begin
                        $error("block_address: expected %h, actual %h",
                               want.addr, block_address);
                        failures++;
                    end
                    if (class_index !== want.cls)
                    begin
                        $error("class_index: expected %0d, actual %0d", want.cls, class_index);
                        failures++;
                    end
                    if (free_blocks !== want.cnt)
                    begin
                        $error("free_blocks: expected %0d, actual %0d", want.cnt, free_blocks);
                        failures++;
                    end
                end
            end
            if (req_valid && req_ready)
                awaited_replies.push_back(serve_request(req_type_t'(req_type), req_size,
                                                        address));
            pending = awaited_replies.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the slab allocator: clock, reset, request and reply drivers, verdict.
`timescale 1ns / 100ps

module tb;
    import slab_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 232;
    localparam int PHASE_COUNT     = 8;

    typedef struct {
        logic [31:0]        addr;
        logic [CLASS_W-1:0] cls;
    } live_block_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    logic [1:0]          req_type;
    logic [31:0]         req_size;
    logic [31:0]         address;
    logic                rsp_valid;
    logic                rsp_ready;
    logic [2:0]          status;
    logic [31:0]         block_address;
    logic [CLASS_W-1:0]  class_index;
    logic [REPORT_W-1:0] free_blocks;
    logic                base_page_we;
    logic [PAGE_W-1:0]   base_page_wdata;
    int                  failures;
    int                  pending;

    int                  sender_idle_pct;
    int                  rsp_stall_pct;
    bit                  hold_off_request;
    logic [PAGE_W-1:0]   cur_base;
    live_block_t         live_blocks [$];

    slab_size_class_allocator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req_type        (req_type),
        .req_size        (req_size),
        .address         (address),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .status          (status),
        .block_address   (block_address),
        .class_index     (class_index),
        .free_blocks     (free_blocks),
        .base_page_we    (base_page_we),
        .base_page_wdata (base_page_wdata)
    );

    slab_reply_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req_type        (req_type),
        .req_size        (req_size),
        .address         (address),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .status          (status),
        .block_address   (block_address),
        .class_index     (class_index),
        .free_blocks     (free_blocks),
        .base_page_we    (base_page_we),
        .base_page_wdata (base_page_wdata),
        .failures        (failures),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Allocated blocks are collected from the replies so that later frees are well formed.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready && status == ST_ALLOCATED)
            live_blocks.push_back('{block_address, class_index});
    end

    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic [31:0] page_of(int c);
        return 32'((64'(cur_base) + 64'(c)) * 64'(PAGE_BYTES));
    endfunction

    function automatic logic [31:0] size_in_class(int c);
        if (c == 0)
            return $urandom_range(16);
        return $urandom_range((16 << c), (8 << c) + 1);
    endfunction

    // Starts and ends at a falling edge; valid stays high across back-to-back requests.
    task automatic offer_request(req_type_t kind, logic [31:0] size, logic [31:0] addr);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        req_size  <= size;
        address   <= addr;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    task automatic drain_replies();
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_base_page(logic [PAGE_W-1:0] value);
        logic [31:0] shift;
        drain_replies();
        base_page_we    <= 1'b1;
        base_page_wdata <= value;
        @(negedge clk);
        base_page_we    <= 1'b0;
        // The lists keep their slots, so outstanding blocks move with the base.
        shift = 32'(PAGE_W'(value - cur_base)) << $clog2(PAGE_BYTES);
        foreach (live_blocks[i])
            live_blocks[i].addr = live_blocks[i].addr + shift;
        cur_base = value;
    endtask

    task automatic random_request();
        int          pick;
        int          c;
        int          idx;
        live_block_t blk;
        logic [31:0] addr;
        pick = $urandom_range(99);
        if (pick < 45 || (pick < 85 && live_blocks.size() == 0))
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                offer_request(REQ_ALLOC, $urandom, '0);
            else if (pick == 1)
                offer_request(REQ_ALLOC, (32'(MIN_BLOCK_BYTES) << $urandom_range(6))
                              + $urandom_range(1), $urandom);
            else
                offer_request(REQ_ALLOC, size_in_class($urandom_range(6)), '0);
        end
        else if (pick < 85)
        begin
            idx = $urandom_range(live_blocks.size() - 1);
            blk = live_blocks[idx];
            live_blocks.delete(idx);
            addr = blk.addr;
            if ($urandom_range(3) == 0)
                addr = addr + $urandom_range((MIN_BLOCK_BYTES << blk.cls) - 1);
            if ($urandom_range(1) == 0)
                offer_request(REQ_FREE_SIZED, size_in_class(int'(blk.cls)), addr);
            else
                offer_request(REQ_FREE_PTR, $urandom, addr);
        end
        else
        begin
            pick = $urandom_range(5);
            c = $urandom_range(6);
            case (pick)
                0: offer_request($urandom_range(1) ? REQ_FREE_SIZED : REQ_FREE_PTR,
                                 $urandom, '0);
                1: offer_request(REQ_UNUSED, $urandom, $urandom);
                2: offer_request(REQ_FREE_PTR, $urandom, $urandom);
                3: offer_request(REQ_FREE_SIZED, $urandom, $urandom);
                4: offer_request(REQ_FREE_PTR, $urandom, page_of(c) + $urandom_range(4095));
                default: offer_request(REQ_FREE_SIZED, size_in_class(c),
                                       page_of($urandom_range(6)) + $urandom_range(4095));
            endcase
        end
    endtask

    initial
    begin : stimulus
        logic [PAGE_W-1:0] phase_base [PHASE_COUNT];
        phase_base = '{20'd1048568, 20'd1, 20'd7, 20'd0, 20'd1048568, 20'd0, 20'h55555, 20'd1};
        phase_base[3] = PAGE_W'($urandom_range(1048568, 1));
        phase_base[5] = PAGE_W'($urandom_range(1048568, 1));
        rst_n            = 1'b0;
        req_valid        = 1'b0;
        req_type         = REQ_ALLOC;
        req_size         = '0;
        address          = '0;
        base_page_we     = 1'b0;
        base_page_wdata  = '0;
        sender_idle_pct  = 0;
        rsp_stall_pct    = 0;
        hold_off_request = 1'b0;
        cur_base         = PAGE_W'(1);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Size boundaries, the too-large fallback and exhausting the largest class.
        offer_request(REQ_ALLOC, 32'd0, '0);
        offer_request(REQ_ALLOC, 32'd16, '0);
        offer_request(REQ_ALLOC, 32'd17, '0);
        offer_request(REQ_ALLOC, 32'd1024, '0);
        offer_request(REQ_ALLOC, 32'd1025, '0);
        offer_request(REQ_ALLOC, 32'h8000_0000, '0);
        offer_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_request(REQ_ALLOC, 32'd1024, '0);
        offer_request(REQ_ALLOC, 32'd1024, '0);
        offer_request(REQ_ALLOC, 32'd1024, '0);
        offer_request(REQ_ALLOC, 32'd1000, '0);
        // Frees: misaligned, by pointer, null, unused type, wrong page and outside the slab.
        offer_request(REQ_FREE_SIZED, 32'd1024, page_of(6) + 32'd5);
        offer_request(REQ_FREE_PTR, '0, page_of(6) + 32'd3072);
        offer_request(REQ_FREE_SIZED, 32'd16, '0);
        offer_request(REQ_FREE_PTR, 32'hFFFF_FFFF, '0);
        offer_request(REQ_UNUSED, 32'd16, page_of(0));
        offer_request(REQ_FREE_SIZED, 32'd16, page_of(1));
        offer_request(REQ_FREE_SIZED, 32'hFFFF_FFFF, page_of(0));
        offer_request(REQ_FREE_PTR, '0, 32'hFFFF_FFFF);
        offer_request(REQ_FREE_PTR, '0, page_of(7));
        offer_request(REQ_FREE_PTR, '0, page_of(0) - 32'd1);
        offer_request(REQ_FREE_SIZED, 32'd32, page_of(1));
        offer_request(REQ_ALLOC, 32'd600, '0);
        offer_request(REQ_ALLOC, 32'd256, '0);
        offer_request(REQ_ALLOC, 32'd64, '0);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            set_base_page(phase_base[phase]);
            case (phase % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    rsp_stall_pct   = 0;
                    // The receiver stops for a long stretch while requests keep coming.
                    hold_off_request = 1'b1;
                end
                1:
                begin
                    sender_idle_pct = 76;
                    rsp_stall_pct   = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    rsp_stall_pct   = 76;
                end
                default:
                begin
                    sender_idle_pct = 10;
                    rsp_stall_pct   = 10;
                end
            endcase
            repeat (PHASE_ITEMS) random_request();
        end

        drain_replies();
        repeat (4) @(negedge clk);
        if (failures == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
